### rtl/uct_pkg.sv
// Shared types and constants for the unsat core tracer.
package uct_pkg;
  localparam int MaxVars = 1024;
  localparam int AddrW = 10;

  typedef enum logic [2:0] {
    OP_LOAD_ASM = 3'd0, OP_LOAD_TRAIL = 3'd1, OP_LOAD_VAR = 3'd2,
    OP_START = 3'd3, OP_ADVANCE = 3'd4, OP_CLAUSE = 3'd5, OP_NOP6 = 3'd6, OP_NOP7 = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_SEND = 3'd0, K_FETCH = 3'd1, K_CORE = 3'd2, K_DONE = 3'd3,
    K_FAIL_EXIT = 3'd4, K_FAIL_NOEXIT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEED_CORE, PH_SEED_FETCH, PH_WALK, PH_CLAUSE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SEED_RD, S_SEED_CHK, S_WALK_RD, S_WALK_VAR,
    S_WALK_INFO, S_WALK_ASM, S_LIT_RD, S_LIT_CHK
  } state_t;

  typedef struct packed {
    logic        seed_ok;
    logic        trail_ok;
    logic        trail_seen;
    logic        walk_end;
    logic        is_dec;
    logic        level_zero;
    logic        level_bad;
    logic        reason_bad;
    logic        lit_mark;
  } status_t;
endpackage

### rtl/uct_ram.sv
// Generic single-port write, single-port read RAM with registered read.
module uct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/uct_datapath.sv
// Datapath: stores, seen bits, run registers and status flags.
module uct_datapath import uct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  state_t            state,
  input  logic              take,
  input  logic [2:0]        op,
  input  logic [9:0]        index,
  input  logic signed [11:0] literal,
  input  logic              in_stack,
  input  logic [10:0]       decision_level,
  input  logic              is_decision,
  input  logic signed [31:0] clause_id,
  input  logic [10:0]       count_assumptions,
  input  logic [10:0]       count_trail,
  input  logic signed [10:0] conflict_index,
  input  logic [10:0]       num_vars,
  output status_t           st,
  output logic [9:0]        clr_addr,
  output logic signed [31:0] asm_lit,
  output logic signed [31:0] rc_m1,
  output logic [10:0]       core_counter,
  input  logic              core_inc,
  input  logic              core_set1,
  input  logic              run_init,
  input  logic              skip_zero
);
  logic [11:0] asm_q, trail_q;
  logic [12:0] info_q;
  logic [31:0] rsn_q;
  logic [AddrW-1:0] asm_ra, trail_ra, var_ra;
  logic [10:0] height, walk_offset, skip_variable;
  logic [10:0] nass;
  logic [10:0] cur_var;
  logic [11:0] lit_hold;
  logic [AddrW-1:0] ci_q;
  logic seen_q;
  logic [AddrW-1:0] seen_wa;
  logic seen_we, seen_wd;

  function automatic logic [10:0] var_of(input logic [11:0] l);
    logic [11:0] a;
    a = l[11] ? 12'(-l) : l;
    return a[10:0];
  endfunction

  function automatic logic var_ok(input logic [10:0] v, input logic [10:0] n);
    return v != 11'd0 && v <= n && v <= 11'(MaxVars);
  endfunction

  logic ld_a, ld_t, ld_v;
  assign ld_a = take && op == OP_LOAD_ASM;
  assign ld_t = take && op == OP_LOAD_TRAIL;
  assign ld_v = take && op == OP_LOAD_VAR;

  logic [10:0] slot;
  assign slot = height - 11'd1 - walk_offset;

  logic [10:0] tv, av;
  assign tv = var_of(trail_q);
  assign av = var_of(asm_q);

  always_comb begin
    asm_ra = index;
    if (state == S_WALK_INFO) asm_ra = AddrW'(info_q[12:2] - 11'd1);
    else if (state == S_SEED_RD) asm_ra = ci_q;
  end
  assign trail_ra = slot[AddrW-1:0];
  always_comb begin
    var_ra = cur_var[AddrW-1:0] - 10'd1;
    if (state == S_WALK_VAR) var_ra = AddrW'(tv - 11'd1);
    else if (take && op == OP_CLAUSE) var_ra = AddrW'(var_of(literal) - 11'd1);
  end

  uct_ram #(.Width(12), .Depth(MaxVars)) u_asm (.clk, .we(ld_a), .waddr(index),
    .wdata(literal), .raddr(asm_ra), .rdata(asm_q));
  uct_ram #(.Width(12), .Depth(MaxVars)) u_trail (.clk, .we(ld_t), .waddr(index),
    .wdata(literal), .raddr(trail_ra), .rdata(trail_q));
  uct_ram #(.Width(13), .Depth(MaxVars)) u_info (.clk, .we(ld_v), .waddr(index),
    .wdata({decision_level, is_decision, in_stack}), .raddr(var_ra), .rdata(info_q));
  uct_ram #(.Width(32), .Depth(MaxVars)) u_rsn (.clk, .we(ld_v), .waddr(index),
    .wdata(clause_id), .raddr(var_ra), .rdata(rsn_q));
  uct_ram #(.Width(1), .Depth(MaxVars)) u_seen (.clk, .we(seen_we), .waddr(seen_wa),
    .wdata(seen_wd), .raddr(var_ra), .rdata(seen_q));

  always_comb begin
    seen_we = 1'b0;
    seen_wd = 1'b0;
    seen_wa = clr_addr;
    unique case (state)
      S_CLEAR: seen_we = 1'b1;
      S_SEED_CHK: begin
        seen_we = st.seed_ok;
        seen_wd = 1'b1;
        seen_wa = AddrW'(av - 11'd1);
      end
      S_WALK_INFO: begin
        seen_we = seen_q;
        seen_wa = AddrW'(cur_var - 11'd1);
      end
      S_LIT_CHK: begin
        seen_we = st.lit_mark;
        seen_wd = 1'b1;
        seen_wa = AddrW'(cur_var - 11'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      walk_offset <= '0;
      core_counter <= '0;
      skip_variable <= '0;
      height <= '0;
      nass <= '0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + 10'd1;
      else clr_addr <= '0;
      if (run_init) begin
        core_counter <= '0;
        walk_offset <= '0;
        skip_variable <= '0;
        nass <= count_assumptions;
        height <= count_trail;
      end
      if (core_set1) core_counter <= 11'd1;
      if (core_inc) core_counter <= core_counter + 11'd1;
      if (skip_zero) skip_variable <= '0;
      if (state == S_WALK_VAR) walk_offset <= walk_offset + 11'd1;
      if (state == S_WALK_INFO && !seen_q == 1'b0 && !info_q[1]) skip_variable <= cur_var;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK_VAR) cur_var <= tv;
    if (take && op == OP_CLAUSE) begin
      cur_var <= var_of(literal);
      lit_hold <= literal;
    end
    if (take && op == OP_START) ci_q <= conflict_index[9:0];
  end

  assign asm_lit = 32'(signed'(asm_q));
  assign rc_m1 = rsn_q - 32'd1;

  always_comb begin
    st.seed_ok = var_ok(av, num_vars);
    st.trail_ok = var_ok(tv, num_vars);
    st.trail_seen = seen_q;
    st.walk_end = walk_offset >= height;
    st.is_dec = info_q[1];
    st.level_zero = info_q[12:2] == 11'd0;
    st.level_bad = info_q[12:2] > nass || core_counter >= nass;
    st.reason_bad = $signed(rsn_q) <= 0;
    st.lit_mark = var_ok(cur_var, num_vars) && cur_var != skip_variable && info_q[0]
                  && info_q[12:2] != 11'd0 && lit_hold != 12'd0;
  end
endmodule

### rtl/uct_ctrl.sv
// Controller state machine for the unsat core tracer.
module uct_ctrl import uct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic signed [11:0] literal,
  input  logic signed [31:0] clause_id,
  input  logic               unsat_present,
  input  logic [10:0]        count_assumptions,
  input  logic [10:0]        count_trail,
  input  logic signed [10:0] conflict_index,
  input  logic [10:0]        num_vars,
  input  status_t            st,
  input  logic [9:0]         clr_addr,
  input  logic signed [31:0] asm_lit,
  input  logic signed [31:0] rc_m1,
  output state_t             state,
  output logic               busy,
  output logic               take,
  output logic               done,
  output logic [2:0]         kind,
  output logic signed [31:0] value,
  output logic               core_inc,
  output logic               core_set1,
  output logic               run_init,
  output logic               skip_zero
);
  state_t state_next;
  phase_t phase, phase_next;
  logic signed [31:0] pending, pending_next;
  logic clause_ok, clause_ok_next;
  logic o_v;
  logic [2:0] o_k;
  logic signed [31:0] o_val;
  logic seed_core, seed_core_next;
  logic [11:0] lit_q;
  logic lit_var_ok;
  logic [11:0] la;

  assign busy = state != S_IDLE;
  assign take = start && !busy;

  assign la = lit_q[11] ? 12'(-lit_q) : lit_q;
  assign lit_var_ok = la[10:0] != 11'd0 && la[10:0] <= num_vars && la[10:0] <= 11'(MaxVars);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      clause_ok <= 1'b1;
      done <= 1'b0;
      seed_core <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      clause_ok <= clause_ok_next;
      done <= o_v;
      seed_core <= seed_core_next;
    end
    pending <= pending_next;
    kind <= o_k;
    value <= o_val;
    if (take) lit_q <= literal;
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    pending_next = pending;
    clause_ok_next = clause_ok;
    seed_core_next = seed_core;
    o_v = 1'b0;
    o_k = K_SEND;
    o_val = '0;
    core_inc = 1'b0;
    core_set1 = 1'b0;
    run_init = 1'b0;
    skip_zero = 1'b0;
    unique case (state)
      S_IDLE: if (take) begin
        unique case (op_t'(op))
          OP_START: begin
            if (num_vars > 11'(MaxVars) || count_assumptions > num_vars
                || count_trail > num_vars) begin
              o_v = 1'b1; o_k = K_FAIL_NOEXIT; phase_next = PH_IDLE;
            end else begin
              run_init = 1'b1;
              clause_ok_next = 1'b1;
              if (!conflict_index[10]) begin
                seed_core_next = 1'b1;
                if (11'(conflict_index) >= count_assumptions) begin
                  o_v = 1'b1; o_k = K_FAIL_EXIT; phase_next = PH_IDLE;
                end else state_next = S_CLEAR;
              end else begin
                seed_core_next = 1'b0;
                if (!unsat_present || clause_id <= 0) begin
                  o_v = 1'b1; o_k = K_FAIL_EXIT; phase_next = PH_IDLE;
                end else begin
                  pending_next = clause_id - 32'd1;
                  state_next = S_CLEAR;
                end
              end
            end
          end
          OP_ADVANCE: begin
            unique case (phase)
              PH_SEED_CORE: begin
                core_set1 = 1'b1; phase_next = PH_WALK;
                o_v = 1'b1; o_k = K_CORE; o_val = pending;
              end
              PH_SEED_FETCH: begin
                skip_zero = 1'b1; clause_ok_next = 1'b1; phase_next = PH_CLAUSE;
                o_v = 1'b1; o_k = K_FETCH; o_val = pending;
              end
              PH_WALK: state_next = S_WALK_RD;
              default: ;
            endcase
          end
          OP_CLAUSE: if (phase == PH_CLAUSE) begin
            if (literal == 12'sd0) begin
              if (!clause_ok) begin
                o_v = 1'b1; o_k = K_FAIL_EXIT; phase_next = PH_IDLE;
              end else phase_next = PH_WALK;
            end else state_next = S_LIT_RD;
          end
          default: ;
        endcase
      end
      S_CLEAR: if (clr_addr == 10'(MaxVars - 1)) begin
        if (seed_core) state_next = S_SEED_RD;
        else begin
          phase_next = PH_SEED_FETCH;
          o_v = 1'b1; o_k = K_SEND;
          state_next = S_IDLE;
        end
      end
      S_SEED_RD: state_next = S_SEED_CHK;
      S_SEED_CHK: begin
        state_next = S_IDLE;
        o_v = 1'b1;
        if (!st.seed_ok) begin
          o_k = K_FAIL_EXIT; phase_next = PH_IDLE;
        end else begin
          o_k = K_SEND; pending_next = asm_lit; phase_next = PH_SEED_CORE;
        end
      end
      S_WALK_RD: begin
        if (st.walk_end) begin
          o_v = 1'b1; o_k = K_DONE; phase_next = PH_IDLE; state_next = S_IDLE;
        end else state_next = S_WALK_VAR;
      end
      S_WALK_VAR: begin
        if (!st.trail_ok) begin
          o_v = 1'b1; o_k = K_FAIL_EXIT; phase_next = PH_IDLE; state_next = S_IDLE;
        end else state_next = S_WALK_INFO;
      end
      S_WALK_INFO: begin
        if (!st.trail_seen) state_next = S_WALK_RD;
        else if (st.is_dec) begin
          if (st.level_zero) state_next = S_WALK_RD;
          else if (st.level_bad) begin
            o_v = 1'b1; o_k = K_FAIL_EXIT; phase_next = PH_IDLE; state_next = S_IDLE;
          end else state_next = S_WALK_ASM;
        end else begin
          state_next = S_IDLE;
          o_v = 1'b1;
          if (st.reason_bad) begin
            o_k = K_FAIL_EXIT; phase_next = PH_IDLE;
          end else begin
            o_k = K_FETCH; o_val = rc_m1; clause_ok_next = 1'b1; phase_next = PH_CLAUSE;
          end
        end
      end
      S_WALK_ASM: begin
        core_inc = 1'b1;
        o_v = 1'b1; o_k = K_CORE; o_val = asm_lit; state_next = S_IDLE;
      end
      S_LIT_RD: begin
        state_next = S_LIT_CHK;
        if (!(st.seed_ok == st.seed_ok)) state_next = S_LIT_CHK;
      end
      S_LIT_CHK: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_LIT_RD && !lit_var_ok) clause_ok_next = 1'b0;
  end
endmodule

### rtl/unsat_core_tracer_core.sv
// Top level of the unsat core tracer.
// Usage: load assumptions (op 0), trail (op 1) and variable data (op 2).
// Set num_vars via num_vars_we/num_vars_wdata while idle.
// Issue start (op 3): the seen bits are swept clear, the
// seed is checked, and a send word (kind 0) or a failure word follows.
// Each advance (op 4) walks the trail from the top, with a trail read, a
// variable data read and a decision step per trail entry, until it yields one
// word: core literal, clause fetch, done or failure.
// Each clause literal (op 5) goes through a read and a check state; the zero
// terminator and the loads are handled while idle.
// A command is taken when start is high and busy is low. Each result word
// is shown for one cycle with result_valid high; the receiver cannot stall.
// Reset clears the phase, the counters and num_vars to 1024; the stores keep
// undefined content until loaded, and the seen bits are swept at each start that passes its checks.
module unsat_core_tracer_core import uct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [9:0]         index,
  input  logic signed [11:0] literal,
  input  logic               in_stack,
  input  logic [10:0]        decision_level,
  input  logic               is_decision,
  input  logic signed [31:0] clause_id,
  input  logic               unsat_present,
  input  logic [10:0]        count_assumptions,
  input  logic [10:0]        count_trail,
  input  logic signed [10:0] conflict_index,
  input  logic               num_vars_we,
  input  logic [10:0]        num_vars_wdata,
  output logic               result_valid,
  output logic [2:0]         kind,
  output logic signed [31:0] value,
  output logic [10:0]        core_count
);
  logic [10:0] num_vars;
  state_t state;
  status_t st;
  logic take, core_inc, core_set1, run_init, skip_zero;
  logic [9:0] clr_addr;
  logic signed [31:0] asm_lit, rc_m1;
  logic [10:0] core_counter;

  always_ff @(posedge clk) begin
    if (rst) num_vars <= 11'(MaxVars);
    else if (num_vars_we) num_vars <= num_vars_wdata;
  end

  always_ff @(posedge clk) begin
    if (run_init) core_count <= '0;
    else if (core_set1) core_count <= 11'd1;
    else core_count <= core_counter + {10'd0, core_inc};
  end

  uct_datapath u_dp (.clk, .rst, .state, .take, .op, .index, .literal, .in_stack,
    .decision_level, .is_decision, .clause_id, .count_assumptions, .count_trail,
    .conflict_index, .num_vars, .st, .clr_addr, .asm_lit, .rc_m1,
    .core_counter, .core_inc, .core_set1, .run_init, .skip_zero);

  uct_ctrl u_ctrl (.clk, .rst, .start, .op, .literal, .clause_id,
    .unsat_present, .count_assumptions, .count_trail, .conflict_index, .num_vars,
    .st, .clr_addr, .asm_lit, .rc_m1, .state, .busy, .take,
    .done(result_valid), .kind, .value, .core_inc, .core_set1, .run_init, .skip_zero);
endmodule
